### rtl/core/sbfcd_pkg.sv
// Package: types and constants shared by the frame channel decoder
`timescale 1ns / 1ps
`default_nettype none

package sbfcd_pkg;

  // frame geometry
  localparam int DataBytes = 22;
  localparam int NumCh     = 16;
  localparam int ChW       = 11;
  localparam int VelW      = 12;
  localparam int PosW      = 5;
  localparam int ChIdxW    = 4;
  localparam int CfgIdxW   = 3;

  localparam logic [ChIdxW-1:0] LastChIdx = ChIdxW'(NumCh - 1);
  localparam logic [PosW-1:0]   LastPos   = PosW'(DataBytes);

  // register reset values
  localparam logic [ChW-1:0] LossThresholdRst = 11'd100;
  localparam logic [ChW-1:0] StickCenterRst   = 11'd1000;
  localparam logic [ChW-1:0] StopLowRst       = 11'd190;
  localparam logic [ChW-1:0] StopHighRst      = 11'd210;
  localparam logic [ChW-1:0] NormalLowRst     = 11'd990;
  localparam logic [ChW-1:0] NormalHighRst    = 11'd1100;
  localparam logic [ChW-1:0] HomeLowRst       = 11'd1700;
  localparam logic [ChW-1:0] HomeHighRst      = 11'd1900;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_LOSS_THRESHOLD = 3'd0,
    REG_STICK_CENTER   = 3'd1,
    REG_STOP_LOW       = 3'd2,
    REG_STOP_HIGH      = 3'd3,
    REG_NORMAL_LOW     = 3'd4,
    REG_NORMAL_HIGH    = 3'd5,
    REG_HOME_LOW       = 3'd6,
    REG_HOME_HIGH      = 3'd7
  } reg_idx_t;

  // drive modes
  typedef enum logic [1:0] {
    DRIVE_HALT   = 2'd0,
    DRIVE_CRUISE = 2'd1,
    DRIVE_HOME   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [ChW-1:0] loss_threshold;
    logic [ChW-1:0] stick_center;
    logic [ChW-1:0] stop_low;
    logic [ChW-1:0] stop_high;
    logic [ChW-1:0] normal_low;
    logic [ChW-1:0] normal_high;
    logic [ChW-1:0] home_low;
    logic [ChW-1:0] home_high;
  } cfg_t;

  // link status held between frames
  typedef struct packed {
    logic                   connected;
    mode_t                  mode;
    logic signed [VelW-1:0] vel_x;
    logic signed [VelW-1:0] vel_y;
    logic signed [VelW-1:0] vel_turn;
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [ChIdxW-1:0]      channel_index;
    logic [ChW-1:0]         channel_value;
    logic                   last_channel;
    logic                   link_connected;
    logic [1:0]             drive_mode;
    logic signed [VelW-1:0] velocity_x;
    logic signed [VelW-1:0] velocity_y;
    logic signed [VelW-1:0] velocity_turn;
  } out_t;

endpackage

`default_nettype wire

### rtl/core/sbfcd_decode.sv
// Channel unpacking and link status update for one complete frame
`timescale 1ns / 1ps
`default_nettype none

module sbfcd_decode (
  input  wire logic [7:0]                   frame_bytes [sbfcd_pkg::DataBytes],
  input  wire sbfcd_pkg::cfg_t              cfg,
  input  wire sbfcd_pkg::status_t           held,
  output logic [sbfcd_pkg::ChW-1:0]         ch [sbfcd_pkg::NumCh],
  output sbfcd_pkg::status_t                status_nxt
);

  localparam int BitsW = 8 * sbfcd_pkg::DataBytes;

  logic [BitsW-1:0]          bits;
  logic [sbfcd_pkg::ChW-1:0] ch4;
  logic                      in_stop;
  logic                      in_normal;
  logic                      in_home;

  // frame data as one little-endian bit string
  always_comb begin
    for (int i = 0; i < sbfcd_pkg::DataBytes; i++) begin
      bits[8*i +: 8] = frame_bytes[i];
    end
  end

  // channel k sits at bits 11k..11k+10
  always_comb begin
    for (int k = 0; k < sbfcd_pkg::NumCh; k++) begin
      ch[k] = bits[sbfcd_pkg::ChW*k +: sbfcd_pkg::ChW];
    end
  end

  // open mode windows on channel four
  assign ch4       = ch[4];
  assign in_stop   = (ch4 > cfg.stop_low)   && (ch4 < cfg.stop_high);
  assign in_normal = (ch4 > cfg.normal_low) && (ch4 < cfg.normal_high);
  assign in_home   = (ch4 > cfg.home_low)   && (ch4 < cfg.home_high);

  // link loss forces stop and keeps velocities
  always_comb begin
    status_nxt = held;
    if (ch[2] < cfg.loss_threshold) begin
      status_nxt.connected = 1'b0;
      status_nxt.mode      = sbfcd_pkg::DRIVE_HALT;
    end else begin
      status_nxt.connected = 1'b1;
      if (in_stop) begin
        status_nxt.mode = sbfcd_pkg::DRIVE_HALT;
      end else if (in_normal) begin
        status_nxt.mode = sbfcd_pkg::DRIVE_CRUISE;
      end else if (in_home) begin
        status_nxt.mode = sbfcd_pkg::DRIVE_HOME;
      end
      status_nxt.vel_x    = $signed({1'b0, ch[0]}) - $signed({1'b0, cfg.stick_center});
      status_nxt.vel_y    = $signed({1'b0, ch[1]}) - $signed({1'b0, cfg.stick_center});
      status_nxt.vel_turn = $signed({1'b0, ch[3]}) - $signed({1'b0, cfg.stick_center});
    end
  end

endmodule

`default_nettype wire

### rtl/core/sbus_frame_channel_decoder.sv
// Top level of the serial radio-control frame decoder
`timescale 1ns / 1ps
`default_nettype none

// Takes one frame byte per cycle. A byte with frame_start high is the header;
// the next 22 bytes are collected. Once the 22nd byte is in and no earlier
// burst is still draining, the sixteen 11-bit channels are unpacked, link
// status, drive mode and velocities updated, and a burst of 16 results
// (channel 0 to 15) is loaded into an output shift register that sends one
// result per cycle while out_stall is low. Bytes after the 22nd are ignored
// until the next header. Input bytes are taken every cycle; the input stalls
// only while a complete frame waits for the previous burst of 16 results to
// drain. The last data byte sets pending_r; the burst registers then load
// with the first result. A frame is at least 23 bytes and a burst 16 results,
// so with the output taking a result each cycle the burst overlaps the next
// frame and the input never stalls: the sustained rate is one byte per cycle.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata.
module sbus_frame_channel_decoder (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire sbfcd_pkg::in_t                    in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output sbfcd_pkg::out_t                        out_data,
  input  wire logic                              cfg_we,
  input  wire logic [sbfcd_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [sbfcd_pkg::ChW-1:0]         cfg_wdata
);

  sbfcd_pkg::cfg_t                  cfg_r;
  sbfcd_pkg::status_t               status_r;
  sbfcd_pkg::status_t               status_nxt;
  logic [7:0]                       frame_bytes_r [sbfcd_pkg::DataBytes];
  logic [sbfcd_pkg::PosW-1:0]       pos_r;
  logic [sbfcd_pkg::PosW-1:0]       wr_idx;
  logic                             pending_r;
  logic                             burst_r;
  logic [sbfcd_pkg::ChIdxW-1:0]     cnt_r;
  logic [sbfcd_pkg::ChW-1:0]        ch_r [sbfcd_pkg::NumCh];
  logic [sbfcd_pkg::ChW-1:0]        dec_ch [sbfcd_pkg::NumCh];
  logic                             in_acc;
  logic                             out_acc;
  logic                             burst_done;
  logic                             load_go;
  logic                             byte_wr;

  // handshakes
  assign out_acc    = burst_r && !out_stall;
  assign burst_done = out_acc && (cnt_r == sbfcd_pkg::LastChIdx);
  assign load_go    = pending_r && (!burst_r || burst_done);
  assign in_stall   = pending_r && !load_go;
  assign in_acc     = in_valid && !in_stall;
  assign byte_wr    = in_acc && !in_data.frame_start && (pos_r != '0);
  assign wr_idx     = pos_r - sbfcd_pkg::PosW'(1);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.loss_threshold <= sbfcd_pkg::LossThresholdRst;
      cfg_r.stick_center   <= sbfcd_pkg::StickCenterRst;
      cfg_r.stop_low       <= sbfcd_pkg::StopLowRst;
      cfg_r.stop_high      <= sbfcd_pkg::StopHighRst;
      cfg_r.normal_low     <= sbfcd_pkg::NormalLowRst;
      cfg_r.normal_high    <= sbfcd_pkg::NormalHighRst;
      cfg_r.home_low       <= sbfcd_pkg::HomeLowRst;
      cfg_r.home_high      <= sbfcd_pkg::HomeHighRst;
    end else if (cfg_we) begin
      case (sbfcd_pkg::reg_idx_t'(cfg_index))
        sbfcd_pkg::REG_LOSS_THRESHOLD: cfg_r.loss_threshold <= cfg_wdata;
        sbfcd_pkg::REG_STICK_CENTER:   cfg_r.stick_center   <= cfg_wdata;
        sbfcd_pkg::REG_STOP_LOW:       cfg_r.stop_low       <= cfg_wdata;
        sbfcd_pkg::REG_STOP_HIGH:      cfg_r.stop_high      <= cfg_wdata;
        sbfcd_pkg::REG_NORMAL_LOW:     cfg_r.normal_low     <= cfg_wdata;
        sbfcd_pkg::REG_NORMAL_HIGH:    cfg_r.normal_high    <= cfg_wdata;
        sbfcd_pkg::REG_HOME_LOW:       cfg_r.home_low       <= cfg_wdata;
        sbfcd_pkg::REG_HOME_HIGH:      cfg_r.home_high      <= cfg_wdata;
        default:                       cfg_r                <= cfg_r;
      endcase
    end
  end

  // byte position tracking and frame completion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      pending_r <= 1'b0;
    end else begin
      if (load_go) begin
        pending_r <= 1'b0;
      end
      if (in_acc) begin
        if (in_data.frame_start) begin
          pos_r <= sbfcd_pkg::PosW'(1);
        end else if (pos_r != '0) begin
          if (pos_r == sbfcd_pkg::LastPos) begin
            pos_r     <= '0;
            pending_r <= 1'b1;
          end else begin
            pos_r <= pos_r + sbfcd_pkg::PosW'(1);
          end
        end
      end
    end
  end

  // frame data store
  always_ff @(posedge clk) begin
    if (byte_wr) begin
      frame_bytes_r[wr_idx] <= in_data.data_byte;
    end
  end

  sbfcd_decode u_decode (
    .frame_bytes (frame_bytes_r),
    .cfg         (cfg_r),
    .held        (status_r),
    .ch          (dec_ch),
    .status_nxt  (status_nxt)
  );

  // held link status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= '0;
    end else if (load_go) begin
      status_r <= status_nxt;
    end
  end

  // result burst control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r <= 1'b0;
      cnt_r   <= '0;
    end else if (load_go) begin
      burst_r <= 1'b1;
      cnt_r   <= '0;
    end else if (out_acc) begin
      cnt_r <= cnt_r + sbfcd_pkg::ChIdxW'(1);
      if (burst_done) begin
        burst_r <= 1'b0;
      end
    end
  end

  // channel shift register, head is the current result
  always_ff @(posedge clk) begin
    if (load_go) begin
      ch_r <= dec_ch;
    end else if (out_acc) begin
      for (int i = 0; i < sbfcd_pkg::NumCh - 1; i++) begin
        ch_r[i] <= ch_r[i+1];
      end
    end
  end

  // result payload
  assign out_valid = burst_r;
  always_comb begin
    out_data.channel_index  = cnt_r;
    out_data.channel_value  = ch_r[0];
    out_data.last_channel   = (cnt_r == sbfcd_pkg::LastChIdx);
    out_data.link_connected = status_r.connected;
    out_data.drive_mode     = status_r.mode;
    out_data.velocity_x     = status_r.vel_x;
    out_data.velocity_y     = status_r.vel_y;
    out_data.velocity_turn  = status_r.vel_turn;
  end

endmodule

`default_nettype wire
